// ----- rtl/mqfb_pkg.sv -----
package mqfb_pkg;

	// request opcodes
	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TAKE = 1'b1;

	// result status codes
	localparam logic [1:0] STS_ADDED  = 2'd0;
	localparam logic [1:0] STS_FULL   = 2'd1;
	localparam logic [1:0] STS_SERVED = 2'd2;
	localparam logic [1:0] STS_EMPTY  = 2'd3;

	// capacity limit after reset
	localparam logic [3:0] CAP_RESET = 4'd5;

	// parameter defaults
	localparam int DEF_NUM_QUEUES  = 32;
	localparam int DEF_QUEUE_DEPTH = 8;
	localparam int DEF_ID_WIDTH    = 16;

	// one request
	typedef struct packed {
		logic        opcode;
		logic [4:0]  queue_index;
		logic [15:0] entry_id;
		logic        urgent;
	} mqfb_in_t;

	// one result
	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] served_id;
		logic        served_urgent;
		logic [3:0]  new_length;
	} mqfb_out_t;

	// controller to datapath
	typedef struct packed {
		logic capture;
		logic look;
		logic finish;
	} mqfb_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic need_read;
	} mqfb_sts_t;

endpackage

// ----- rtl/mqfb_ctrl.sv -----
module mqfb_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  mqfb_pkg::mqfb_sts_t sts,
	output logic              busy,
	output mqfb_pkg::mqfb_cmd_t cmd
);
	import mqfb_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_LOOK = 3'b010,
		ST_READ = 3'b100
	} state_t;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				state_d = sts.need_read ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// commands to the datapath
	assign busy        = (state_q != ST_IDLE);
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.look    = (state_q == ST_LOOK);
	assign cmd.finish  = (state_q == ST_READ);

endmodule

// ----- rtl/mqfb_dpath.sv -----
module mqfb_dpath #(
	parameter int NUM_QUEUES  = mqfb_pkg::DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH = mqfb_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH    = mqfb_pkg::DEF_ID_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  mqfb_pkg::mqfb_in_t  req,
	input  mqfb_pkg::mqfb_cmd_t cmd,
	output mqfb_pkg::mqfb_sts_t sts,
	output logic                done,
	output mqfb_pkg::mqfb_out_t result
);
	import mqfb_pkg::*;

	localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam int HW = $clog2(QUEUE_DEPTH);
	localparam int LW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = ((HW > LW) ? HW : LW) + 1;
	localparam int IW = (ID_WIDTH < 16) ? ID_WIDTH : 16;
	localparam int PW = LW + HW;

	// capacity register
	logic [3:0] cap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	// pointer memory: {length, head} per queue, valid bit stands for reset
	logic [PW-1:0]         ptr_mem [NUM_QUEUES];
	logic [NUM_QUEUES-1:0] ptr_vld_q;
	logic [PW-1:0]         ptr_rd_q;
	logic                  vld_rd_q;
	mqfb_in_t              item_q;
	logic [QW-1:0]         qsel_in;
	logic [QW-1:0]         qsel;

	assign qsel_in = QW'(req.queue_index);
	assign qsel    = QW'(item_q.queue_index);

	// capture request and read pointers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q   <= req;
			ptr_rd_q <= ptr_mem[qsel_in];
			vld_rd_q <= ptr_vld_q[qsel_in];
		end
	end

	// lookup cycle arithmetic
	logic [LW-1:0] len;
	logic [HW-1:0] head;
	logic [LW-1:0] cap_eff;
	logic          q_ok;
	logic          full;
	logic          add_ok;
	logic          take_ok;
	logic [HW-1:0] head_dec;
	logic [HW-1:0] head_inc;
	logic [SW-1:0] tail_sum;
	logic [HW-1:0] tail;
	logic [HW-1:0] add_slot;

	always_comb begin
		len      = vld_rd_q ? ptr_rd_q[PW-1:HW] : '0;
		head     = vld_rd_q ? ptr_rd_q[HW-1:0] : '0;
		q_ok     = int'(item_q.queue_index) < NUM_QUEUES;
		cap_eff  = (int'(cap_q) > QUEUE_DEPTH) ? LW'(QUEUE_DEPTH) : LW'(cap_q);
		full     = (len >= cap_eff);
		add_ok   = q_ok && (item_q.opcode == OP_ADD) && !full;
		take_ok  = q_ok && (item_q.opcode == OP_TAKE) && (len != '0);
		head_dec = (head == '0) ? HW'(QUEUE_DEPTH - 1) : head - HW'(1);
		head_inc = (head == HW'(QUEUE_DEPTH - 1)) ? '0 : head + HW'(1);
		tail_sum = SW'(head) + SW'(len);
		tail     = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
		                                          : HW'(tail_sum);
		add_slot = item_q.urgent ? head_dec : tail;
	end

	assign sts.need_read = take_ok;

	// pointer write back
	always_ff @(posedge clk) begin
		if (cmd.look && add_ok) begin
			ptr_mem[qsel] <= {len + LW'(1), item_q.urgent ? head_dec : head};
		end else if (cmd.look && take_ok) begin
			ptr_mem[qsel] <= {len - LW'(1), head_inc};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_vld_q <= '0;
		end else if (cmd.look && (add_ok || take_ok)) begin
			ptr_vld_q[qsel] <= 1'b1;
		end
	end

	// entry memory: {urgent, id}, one port
	logic [IW:0]   entry_mem [NUM_QUEUES << HW];
	logic [IW:0]   entry_rd_q;
	logic [LW-1:0] len_dec_q;

	always_ff @(posedge clk) begin
		if (cmd.look && add_ok) begin
			entry_mem[{qsel, add_slot}] <= {item_q.urgent, item_q.entry_id[IW-1:0]};
		end else if (cmd.look && take_ok) begin
			entry_rd_q <= entry_mem[{qsel, head}];
			len_dec_q  <= len - LW'(1);
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			result.status        <= STS_SERVED;
			result.served_id     <= 16'(entry_rd_q[IW-1:0]);
			result.served_urgent <= entry_rd_q[IW];
			result.new_length    <= 4'(len_dec_q);
		end else if (cmd.look && !take_ok) begin
			result.served_id     <= '0;
			result.served_urgent <= 1'b0;
			priority if (!q_ok) begin
				result.status     <= (item_q.opcode == OP_TAKE) ? STS_EMPTY : STS_FULL;
				result.new_length <= '0;
			end else if (item_q.opcode == OP_TAKE) begin
				result.status     <= STS_EMPTY;
				result.new_length <= '0;
			end else if (full) begin
				result.status     <= STS_FULL;
				result.new_length <= 4'(len);
			end else begin
				result.status     <= STS_ADDED;
				result.new_length <= 4'(len + LW'(1));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.finish || (cmd.look && !take_ok);
		end
	end

endmodule

// ----- rtl/multi_queue_front_back_insert_top.sv -----
// Bank of NUM_QUEUES bounded double-ended queues. A request is taken when start is high
// and busy is low; an add puts entry_id at the tail, or at the head when urgent, and a
// take pops the head. Each request gives exactly one result, shown on result for a single
// cycle with done high; the receiver cannot stall it, so it must take it then. An add
// passes through the look state and a take through the look and read states before its
// result: the per-queue pointer memory is read with a registered port, and a take then
// reads the entry memory, also registered. busy drops in the cycle the result appears,
// so a new request may be given with it. There is no clearing pass after reset: per-queue
// valid bits cover the pointer memory. The capacity limit may be written with cfg_wr_en
// only while no request is open.
module multi_queue_front_back_insert_top #(
	parameter int NUM_QUEUES  = mqfb_pkg::DEF_NUM_QUEUES,
	parameter int QUEUE_DEPTH = mqfb_pkg::DEF_QUEUE_DEPTH,
	parameter int ID_WIDTH    = mqfb_pkg::DEF_ID_WIDTH
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [3:0]          cfg_wr_data,
	input  logic                start,
	output logic                busy,
	input  mqfb_pkg::mqfb_in_t  req,
	output logic                done,
	output mqfb_pkg::mqfb_out_t result
);
	import mqfb_pkg::*;

	mqfb_cmd_t cmd;
	mqfb_sts_t sts;

	// controller
	mqfb_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// datapath
	mqfb_dpath #(
		.NUM_QUEUES  (NUM_QUEUES),
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.ID_WIDTH    (ID_WIDTH)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.req         (req),
		.cmd         (cmd),
		.sts         (sts),
		.done        (done),
		.result      (result)
	);

	// result only appears once the controller is free again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result while busy");

	// an accepted request holds the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but not busy");

	// results are never in consecutive cycles
	a_done_gap: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("results in consecutive cycles");

	// served fields are zero unless served
	a_served_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (result.status != STS_SERVED)) |->
		((result.served_id == '0) && !result.served_urgent))
		else $error("served fields set on non-served result");

endmodule

// ----- tb/multi_queue_front_back_insert_top_tb.sv -----
`timescale 1ns / 1ps

module multi_queue_front_back_insert_top_tb;
	import mqfb_pkg::*;

	localparam int NQ     = DEF_NUM_QUEUES;
	localparam int QDEPTH = DEF_QUEUE_DEPTH;
	localparam int RANDOM_ITEMS = 1900;
	localparam int PHASES       = 10;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       cfg_wr_en   = 1'b0;
	logic [3:0] cfg_wr_data = '0;
	logic       start       = 1'b0;
	logic       busy;
	mqfb_in_t   req         = '0;
	logic       done;
	mqfb_out_t  result;

	multi_queue_front_back_insert_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.start      (start),
		.busy       (busy),
		.req        (req),
		.done       (done),
		.result     (result)
	);

	// 2 ns clock
	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// shadow copy of the queue bank
	logic [15:0] shadow_ids [NQ][QDEPTH];
	logic        shadow_urg [NQ][QDEPTH];
	int          shadow_len [NQ];
	int          shadow_head [NQ];
	logic [3:0]  shadow_cap = CAP_RESET;

	mqfb_out_t pending_outcomes [$];
	int        error_count = 0;

	// directed request with an optional hand-typed outcome
	typedef struct {
		mqfb_in_t  item;
		bit        typed;
		mqfb_out_t want;
	} directed_row_t;

	localparam int N_DIRECTED = 18;
	directed_row_t directed [N_DIRECTED] = '{
		// take from an untouched queue
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b1,
			mqfb_out_t'{STS_EMPTY, 16'h0000, 1'b0, 4'd0}},
		// top queue, top id, urgent
		'{mqfb_in_t'{OP_ADD, 5'd31, 16'hFFFF, 1'b1}, 1'b1,
			mqfb_out_t'{STS_ADDED, 16'h0000, 1'b0, 4'd1}},
		'{mqfb_in_t'{OP_TAKE, 5'd31, 16'h0000, 1'b0}, 1'b1,
			mqfb_out_t'{STS_SERVED, 16'hFFFF, 1'b1, 4'd0}},
		// fill queue 0 to the reset capacity, mixing head and tail inserts
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h0000, 1'b0}, 1'b1,
			mqfb_out_t'{STS_ADDED, 16'h0000, 1'b0, 4'd1}},
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h1234, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h0AAA, 1'b1}, 1'b0, '0},
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h5555, 1'b1}, 1'b0, '0},
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'hFFFF, 1'b0}, 1'b1,
			mqfb_out_t'{STS_ADDED, 16'h0000, 1'b0, 4'd5}},
		// refused when full, either end
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h0001, 1'b0}, 1'b1,
			mqfb_out_t'{STS_FULL, 16'h0000, 1'b0, 4'd5}},
		'{mqfb_in_t'{OP_ADD, 5'd0, 16'h0002, 1'b1}, 1'b1,
			mqfb_out_t'{STS_FULL, 16'h0000, 1'b0, 4'd5}},
		// drain across the ring wrap
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'hFFFF, 1'b1}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd0, 16'h0000, 1'b0}, 1'b1,
			mqfb_out_t'{STS_EMPTY, 16'h0000, 1'b0, 4'd0}},
		'{mqfb_in_t'{OP_ADD, 5'd16, 16'h8000, 1'b0}, 1'b0, '0},
		'{mqfb_in_t'{OP_TAKE, 5'd16, 16'h0000, 1'b0}, 1'b0, '0}
	};

	// outcome of one request, updating the shadow bank
	function automatic mqfb_out_t deque_outcome(input mqfb_in_t r);
		mqfb_out_t o;
		int q, n, h, cap, slot;
		o = '0;
		q = int'(r.queue_index);
		n = shadow_len[q];
		h = shadow_head[q];
		if (r.opcode == OP_ADD) begin
			cap = (int'(shadow_cap) > QDEPTH) ? QDEPTH : int'(shadow_cap);
			if (n >= cap) begin
				o.status     = STS_FULL;
				o.new_length = 4'(n);
			end else begin
				// urgent goes in front of the head, regular after the tail
				if (r.urgent) begin
					h = (h + QDEPTH - 1) % QDEPTH;
					slot = h;
					shadow_head[q] = h;
				end else begin
					slot = (h + n) % QDEPTH;
				end
				shadow_ids[q][slot] = r.entry_id;
				shadow_urg[q][slot] = r.urgent;
				shadow_len[q] = n + 1;
				o.status     = STS_ADDED;
				o.new_length = 4'(n + 1);
			end
		end else if (n == 0) begin
			o.status = STS_EMPTY;
		end else begin
			o.status        = STS_SERVED;
			o.served_id     = shadow_ids[q][h];
			o.served_urgent = shadow_urg[q][h];
			shadow_head[q]  = (h + 1) % QDEPTH;
			shadow_len[q]   = n - 1;
			o.new_length    = 4'(n - 1);
		end
		return o;
	endfunction

	task automatic log_mismatch(input string what, input mqfb_out_t want, input mqfb_out_t got);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s: want sts=%0d id=%h urg=%0d len=%0d got sts=%0d id=%h urg=%0d len=%0d",
				$realtime, what, want.status, want.served_id, want.served_urgent,
				want.new_length, got.status, got.served_id, got.served_urgent,
				got.new_length);
	endtask

	// mostly back to back, some short gaps, a few long ones
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 60)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 40);
	endfunction

	// present one request and wait for it to be taken
	task automatic issue(input mqfb_in_t item, input int gap, input bit typed,
		input mqfb_out_t want);
		mqfb_out_t predicted;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req   <= item;
		do @(posedge clk); while (busy);
		predicted = deque_outcome(item);
		pending_outcomes.push_back(typed ? want : predicted);
	endtask

	// hold off until every outstanding request has answered
	task automatic drain();
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [3:0] value);
		drain();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		shadow_cap = value;
	endtask

	// result checker
	always @(posedge clk) begin
		mqfb_out_t want;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				log_mismatch("result with no request open", '0, result);
			end else begin
				want = pending_outcomes.pop_front();
				if (result.status != want.status || result.served_id != want.served_id ||
					result.served_urgent != want.served_urgent ||
					result.new_length != want.new_length)
					log_mismatch("result mismatch", want, result);
			end
		end
	end

	// stimulus
	initial begin
		logic [3:0] caps [PHASES];
		int         hot [4];
		int         per_phase, add_pct, rows;
		bit         calm;
		mqfb_in_t   item;

		for (int q = 0; q < NQ; q++) begin
			shadow_len[q]  = 0;
			shadow_head[q] = 0;
		end
		caps = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd9, 4'd5, 4'd2, 4'd7, 4'd8};

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed walk at the reset capacity
		for (int i = 0; i < N_DIRECTED; i++)
			issue(directed[i].item, pick_gap(1'b0), directed[i].typed, directed[i].want);

		// random phases, each with its own capacity and traffic mix
		per_phase = RANDOM_ITEMS / PHASES;
		for (int p = 0; p < PHASES; p++) begin
			if (p >= 6)
				caps[p] = 4'($urandom_range(1, 8));
			set_capacity(caps[p]);
			for (int k = 0; k < 4; k++)
				hot[k] = $urandom_range(0, NQ - 1);
			add_pct = $urandom_range(35, 75);
			calm    = ($urandom_range(0, 3) == 0);
			rows    = per_phase;
			for (int i = 0; i < rows; i++) begin
				item.opcode      = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_TAKE;
				item.queue_index = ($urandom_range(0, 9) < 7) ? 5'(hot[$urandom_range(0, 3)])
				                                              : 5'($urandom_range(0, NQ - 1));
				item.entry_id    = 16'($urandom);
				item.urgent      = 1'($urandom);
				// flip the mix half way so queues both fill and drain
				if (i == rows / 2)
					add_pct = 100 - add_pct;
				if ($urandom_range(0, 99) == 0)
					drain();
				issue(item, pick_gap(calm), 1'b0, '0);
			end
		end

		// wind down
		start <= 1'b0;
		while (pending_outcomes.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

	// count an unknown start after reset as an error
	always @(posedge clk) begin
		if (arst_n && start === 1'bx)
			error_count++;
	end

	// watchdog
	initial begin
		#1_000_000;
		$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/mqfb_pkg.sv
rtl/mqfb_ctrl.sv
rtl/mqfb_dpath.sv
rtl/multi_queue_front_back_insert_top.sv
tb/multi_queue_front_back_insert_top_tb.sv
